// ===== rtl/tace_pkg.sv =====
// ----------------------------------------------------------------------------
// tace_pkg
// Opcodes and fixed constants of the accumulator machine execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package tace_pkg;

	// Opcode encodings of the decoded instruction beat
	localparam logic [7:0] OP_NOP   = 8'd0;
	localparam logic [7:0] OP_COPY  = 8'd1;
	localparam logic [7:0] OP_LOADI = 8'd2;
	localparam logic [7:0] OP_ADDM  = 8'd6;
	localparam logic [7:0] OP_ADDI  = 8'd7;
	localparam logic [7:0] OP_INC   = 8'd10;
	localparam logic [7:0] OP_DEC   = 8'd11;
	localparam logic [7:0] OP_JNZ   = 8'd24;
	localparam logic [7:0] OP_OUT   = 8'd28;

	// Data word that serves as the accumulator
	localparam int unsigned ACC_WORD = 164;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OPND_W = 16;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [OPND_W-1:0] opnd_t;

endpackage

`default_nettype wire

// ===== rtl/toy_accumulator_cpu_execute.sv =====
// ----------------------------------------------------------------------------
// toy_accumulator_cpu_execute
// Execute stage of a small accumulator machine: data memory, PC and flags.
// ----------------------------------------------------------------------------
// Pipeline: stage 1, stage 2, stage 3, then the output register.
// Throughput: one instruction per cycle unless the result side stalls;
//   stage 3 adds and writes back, with forwarding to the next beat.
// Reset: PC and flags clear at once; the data memory is then zeroed by a
//   sweep over all DATA_DEPTH words during which in_ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module toy_accumulator_cpu_execute
	import tace_pkg::*;
#(
	parameter int unsigned DATA_DEPTH    = 256,
	parameter int unsigned PROGRAM_DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// instruction channel
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [7:0]         action,
	input  wire logic [15:0]        operand_a,
	input  wire logic [15:0]        operand_b,
	// result channel
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic [7:0]         next_pc,
	output      logic               zero_flag,
	output      logic               negative_flag,
	output      logic               print_valid,
	output      logic signed [31:0] print_value
);

	localparam int unsigned AW = $clog2(DATA_DEPTH);
	localparam int unsigned PW = $clog2(PROGRAM_DEPTH);

	// Reciprocals for operand modulo depth: q = (x * RECIP) >> 32 is exact
	// for every 16-bit x.
	localparam logic [31:0] DATA_RECIP = 32'((64'd1 << 32) / DATA_DEPTH + 64'd1);
	localparam logic [31:0] PROG_RECIP = 32'((64'd1 << 32) / PROGRAM_DEPTH + 64'd1);
	localparam logic [16:0] DATA_DEP17 = 17'(DATA_DEPTH);
	localparam logic [16:0] PROG_DEP17 = 17'(PROGRAM_DEPTH);
	localparam logic [AW-1:0] ACC_ADDR = AW'(ACC_WORD % DATA_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DATA_DEPTH - 1);
	localparam logic [PW-1:0] LAST_PC = PW'(PROGRAM_DEPTH - 1);

	// ------------------------------------------------------------------
	// Global advance: every stage moves together when the output register
	// is free or being drained.
	// ------------------------------------------------------------------
	logic adv;
	logic in_acc;
	logic clr_busy_q;
	logic [AW-1:0] clr_idx_q;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv && !clr_busy_q;
	assign in_acc   = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Stage 1: capture the beat, multiply operands by the reciprocals
	// ------------------------------------------------------------------
	logic       v_s1;
	logic [7:0] op_s1;
	opnd_t      a_s1;
	opnd_t      b_s1;
	opnd_t      qa_s1;
	opnd_t      qb_s1;
	opnd_t      qp_s1;
	logic [47:0] prod_a;
	logic [47:0] prod_b;
	logic [47:0] prod_p;

	assign prod_a = 48'(operand_a) * 48'(DATA_RECIP);
	assign prod_b = 48'(operand_b) * 48'(DATA_RECIP);
	assign prod_p = 48'(operand_a) * 48'(PROG_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= action;
			a_s1  <= operand_a;
			b_s1  <= operand_b;
			qa_s1 <= prod_a[47:32];
			qb_s1 <= prod_b[47:32];
			qp_s1 <= prod_p[47:32];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: subtract quotient times depth to get the residues
	// ------------------------------------------------------------------
	logic          v_s2;
	logic [7:0]    op_s2;
	opnd_t         a_s2;
	opnd_t         b_s2;
	logic [AW-1:0] ia_s2;
	logic [AW-1:0] ib_s2;
	logic [PW-1:0] jt_s2;
	logic [16:0]   res_a;
	logic [16:0]   res_b;
	logic [16:0]   res_p;

	assign res_a = {1'b0, a_s1} - 17'({1'b0, qa_s1} * DATA_DEP17);
	assign res_b = {1'b0, b_s1} - 17'({1'b0, qb_s1} * DATA_DEP17);
	assign res_p = {1'b0, a_s1} - 17'({1'b0, qp_s1} * PROG_DEP17);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2 <= op_s1;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			ia_s2 <= res_a[AW-1:0];
			ib_s2 <= res_b[AW-1:0];
			jt_s2 <= res_p[PW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Memory read issue: port 0 fetches the first source, port 1 the
	// addend of an add-from-memory. Both copies are written alike.
	// ------------------------------------------------------------------
	logic [AW-1:0] rd_addr0;
	logic [AW-1:0] rd_addr1;
	word_t         rdata0;
	word_t         rdata1;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	word_t         wr_data;

	always_comb begin
		unique case (op_s2) inside
			OP_ADDM, OP_ADDI: rd_addr0 = ACC_ADDR;
			OP_COPY:          rd_addr0 = ib_s2;
			default:          rd_addr0 = ia_s2;
		endcase
	end
	assign rd_addr1 = ia_s2;

	tace_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DATA_DEPTH)
	) u_ram0 (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (adv),
		.raddr (rd_addr0),
		.rdata (rdata0)
	);

	tace_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DATA_DEPTH)
	) u_ram1 (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (adv),
		.raddr (rd_addr1),
		.rdata (rdata1)
	);

	// ------------------------------------------------------------------
	// Stage 3: execute, write back, update PC and flags
	// ------------------------------------------------------------------
	logic          v_s3;
	logic [7:0]    op_s3;
	opnd_t         a_s3;
	opnd_t         b_s3;
	logic [AW-1:0] ia_s3;
	logic [PW-1:0] jt_s3;
	logic          fwd0_s3;
	logic          fwd1_s3;
	word_t         fwd_data_s3;

	logic [PW-1:0] pc_q;
	logic          zero_q;
	logic          neg_q;

	word_t         src0;
	word_t         src1;
	logic          ex_we;
	logic [AW-1:0] ex_waddr;
	word_t         ex_wdata;
	logic          ex_flags;
	logic          ex_print;
	word_t         ex_shown;
	logic [PW-1:0] pc_inc;
	logic [PW-1:0] pc_nxt;
	logic          zero_nxt;
	logic          neg_nxt;
	logic          commit;
	logic [PW+7:0] pc_ext;

	// Take the word being written back when the read raced it
	assign src0 = fwd0_s3 ? fwd_data_s3 : rdata0;
	assign src1 = fwd1_s3 ? fwd_data_s3 : rdata1;

	assign pc_inc = (pc_q == LAST_PC) ? '0 : pc_q + PW'(1);

	always_comb begin
		ex_we    = 1'b0;
		ex_waddr = ia_s3;
		ex_wdata = src0;
		ex_flags = 1'b0;
		ex_print = 1'b0;
		ex_shown = '0;
		pc_nxt   = pc_inc;
		unique case (op_s3)
			OP_COPY: begin
				ex_we = 1'b1;
			end
			OP_LOADI: begin
				ex_we    = 1'b1;
				ex_wdata = {16'b0, b_s3};
			end
			OP_ADDM: begin
				ex_we    = 1'b1;
				ex_waddr = ACC_ADDR;
				ex_wdata = src0 + src1;
				ex_flags = 1'b1;
			end
			OP_ADDI: begin
				ex_we    = 1'b1;
				ex_waddr = ACC_ADDR;
				ex_wdata = src0 + {16'b0, a_s3};
				ex_flags = 1'b1;
			end
			OP_INC: begin
				ex_we    = 1'b1;
				ex_wdata = src0 + 32'd1;
				ex_flags = 1'b1;
			end
			OP_DEC: begin
				ex_we    = 1'b1;
				ex_wdata = src0 - 32'd1;
				ex_flags = 1'b1;
			end
			OP_JNZ: begin
				if (!zero_q) begin
					pc_nxt = jt_s3;
				end
			end
			OP_OUT: begin
				ex_print = 1'b1;
				ex_shown = src0;
			end
			default: begin
				ex_we = 1'b0;
			end
		endcase
		zero_nxt = ex_flags ? (ex_wdata == '0) : zero_q;
		neg_nxt  = ex_flags ? ex_wdata[WORD_W-1] : neg_q;
	end

	assign commit = v_s3 && adv;
	assign pc_ext = {8'b0, pc_nxt};

	// Write port: the clearing sweep owns it until the memory is zeroed
	assign wr_en   = clr_busy_q || (commit && ex_we);
	assign wr_addr = clr_busy_q ? clr_idx_q : ex_waddr;
	assign wr_data = clr_busy_q ? '0 : ex_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3       <= 1'b0;
			pc_q       <= '0;
			zero_q     <= 1'b0;
			neg_q      <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else begin
			if (adv) begin
				v_s3 <= v_s2;
			end
			if (commit) begin
				pc_q   <= pc_nxt;
				zero_q <= zero_nxt;
				neg_q  <= neg_nxt;
			end
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + AW'(1);
				if (clr_idx_q == LAST_ADDR) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	// Flag a read that meets the write of the beat ahead of it
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3       <= op_s2;
			a_s3        <= a_s2;
			b_s3        <= b_s2;
			ia_s3       <= ia_s2;
			jt_s3       <= jt_s2;
			fwd0_s3     <= v_s3 && ex_we && (ex_waddr == rd_addr0);
			fwd1_s3     <= v_s3 && ex_we && (ex_waddr == rd_addr1);
			fwd_data_s3 <= ex_wdata;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic       out_valid_q;
	logic [7:0] out_pc_q;
	logic       out_zero_q;
	logic       out_neg_q;
	logic       out_pv_q;
	word_t      out_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_pc_q   <= pc_ext[7:0];
			out_zero_q <= zero_nxt;
			out_neg_q  <= neg_nxt;
			out_pv_q   <= ex_print;
			out_val_q  <= ex_shown;
		end
	end

	assign out_valid     = out_valid_q;
	assign next_pc       = out_pc_q;
	assign zero_flag     = out_zero_q;
	assign negative_flag = out_neg_q;
	assign print_valid   = out_pv_q;
	assign print_value   = signed'(out_val_q);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(zero_q && neg_q))
		else $error("zero and negative flags both set");

	a_no_beat_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!v_s1 && !v_s2 && !v_s3 && wr_data == '0))
		else $error("instruction in flight while memory is being cleared");

	a_stall_freezes_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(pc_q) && $stable(zero_q) && $stable(neg_q)))
		else $error("architectural state changed while result stalled");

	a_print_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !print_valid) |-> (print_value == '0))
		else $error("print value nonzero on non-output instruction");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_busy_q |=> !clr_busy_q)
		else $error("memory clear restarted without reset");

endmodule

`default_nettype wire

// ===== rtl/tace_ram.sv =====
// ----------------------------------------------------------------------------
// tace_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tace_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read returns the old word when the same entry is written in the same cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the accumulator machine execute stage: directed
// instruction sequences, then a long random program, with random bubbles on
// the instruction side and random back-pressure on the result side.
// ----------------------------------------------------------------------------

module tb_top
	import tace_pkg::*;
();

	// Opcodes the machine does not implement; they retire as no operation
	localparam logic [7:0] OP_SPARE = 8'd3;
	localparam logic [7:0] OP_TOP   = 8'hFF;
	localparam logic [7:0] OP_HIGH  = 8'h80;

	localparam logic [7:0] ACC_ADDR    = ACC_WORD[7:0];
	localparam int         STALL_LIMIT = 5000;  // idle cycles before the run is declared hung
	localparam int         RANDOM_BEATS = 600;

	// One retired instruction as seen on the result channel
	typedef struct packed {
		logic [7:0] pc;
		logic       zf;
		logic       nf;
		logic       pv;
		word_t      pval;
	} retire_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         action = OP_NOP;
	opnd_t              operand_a = '0;
	opnd_t              operand_b = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         next_pc;
	logic               zero_flag;
	logic               negative_flag;
	logic               print_valid;
	logic signed [31:0] print_value;

	toy_accumulator_cpu_execute dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.next_pc       (next_pc),
		.zero_flag     (zero_flag),
		.negative_flag (negative_flag),
		.print_valid   (print_valid),
		.print_value   (print_value)
	);

	// 20 ns period: high half, then low half
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Machine shadow: data memory, PC and flags, advanced once per
	// accepted instruction beat. Each retirement lands in retire_q.
	// ------------------------------------------------------------------
	word_t      shadow_mem [256];
	logic [7:0] shadow_pc;
	logic       shadow_zf;
	logic       shadow_nf;
	retire_t    retire_q [$];

	int err_count    = 0;
	int beats_sent   = 0;
	int beats_seen   = 0;
	int prints_seen  = 0;
	int jumps_taken  = 0;
	bit bubbles_on   = 1'b1;

	function automatic void clear_shadow();
		foreach (shadow_mem[i])
			shadow_mem[i] = '0;
		shadow_pc = '0;
		shadow_zf = 1'b0;
		shadow_nf = 1'b0;
	endfunction

	function automatic void set_flags(word_t w);
		shadow_zf = (w == '0);
		shadow_nf = w[WORD_W-1];
	endfunction

	// Retire one instruction against the shadow and queue what the block
	// should report for it.
	function automatic void retire_instr(logic [7:0] op, opnd_t a, opnd_t b);
		retire_t    r;
		logic [7:0] ia;
		logic [7:0] nxt;
		ia     = a[7:0];          // 256 data words: low byte is the address
		nxt    = shadow_pc + 8'd1;
		r.pv   = 1'b0;
		r.pval = '0;
		case (op)
			OP_COPY:  shadow_mem[ia] = shadow_mem[b[7:0]];
			OP_LOADI: shadow_mem[ia] = {16'd0, b};
			OP_ADDM: begin
				shadow_mem[ACC_ADDR] = shadow_mem[ACC_ADDR] + shadow_mem[ia];
				set_flags(shadow_mem[ACC_ADDR]);
			end
			OP_ADDI: begin
				shadow_mem[ACC_ADDR] = shadow_mem[ACC_ADDR] + {16'd0, a};
				set_flags(shadow_mem[ACC_ADDR]);
			end
			OP_INC: begin
				shadow_mem[ia] = shadow_mem[ia] + 32'd1;
				set_flags(shadow_mem[ia]);
			end
			OP_DEC: begin
				shadow_mem[ia] = shadow_mem[ia] - 32'd1;
				set_flags(shadow_mem[ia]);
			end
			OP_JNZ: begin
				if (!shadow_zf) begin
					nxt = a[7:0];
					jumps_taken++;
				end
			end
			OP_OUT: begin
				r.pv   = 1'b1;
				r.pval = shadow_mem[ia];
			end
			default: ;
		endcase
		shadow_pc = nxt;
		r.pc = shadow_pc;
		r.zf = shadow_zf;
		r.nf = shadow_nf;
		retire_q.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Gaps: mostly short, a few long
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	// Send one instruction beat. Entered and left at a falling edge; the
	// payload changes only there and holds until the beat is taken.
	task automatic send_instr(logic [7:0] op, opnd_t a, opnd_t b);
		int gap;
		gap = (bubbles_on && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action    <= op;
		operand_a <= a;
		operand_b <= b;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		retire_instr(op, a, b);
		beats_sent++;
		@(negedge clk);
	endtask

	// Result side back-pressure, applied on the falling edge
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (bubbles_on && $urandom_range(0, 99) < 30) begin
			out_ready <= 1'b0;
			stall_left = pick_gap() - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Checking: every result beat against the oldest retirement
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		err_count++;
	endtask

	always @(posedge clk) begin
		retire_t want;
		if (arst_n && out_valid && out_ready) begin
			if (retire_q.size() == 0) begin
				report_mismatch("unexpected result beat", next_pc, 0);
			end else begin
				want = retire_q.pop_front();
				beats_seen++;
				if (print_valid)
					prints_seen++;
				if (next_pc !== want.pc)
					report_mismatch("next_pc", next_pc, want.pc);
				if (zero_flag !== want.zf)
					report_mismatch("zero_flag", zero_flag, want.zf);
				if (negative_flag !== want.nf)
					report_mismatch("negative_flag", negative_flag, want.nf);
				if (print_valid !== want.pv)
					report_mismatch("print_valid", print_valid, want.pv);
				if (print_value !== want.pval)
					report_mismatch("print_value", print_value, want.pval);
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves a beat. The
	// clearing sweep after reset and the longest gaps fit well inside.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[%0t] hung: no beat for %0d cycles, %0d results pending",
				$time, STALL_LIMIT, retire_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// Memory must read back zero after the reset sweep, at both ends too
	task automatic test_after_reset();
		send_instr(OP_OUT, 16'd0, 16'hFFFF);
		send_instr(OP_OUT, 16'(ACC_WORD), 16'd0);
		send_instr(OP_OUT, 16'hFFFF, 16'd0);
		send_instr(OP_NOP, 16'hFFFF, 16'hFFFF);
	endtask

	// Load immediates, copy, and operands whose upper bits must be dropped
	task automatic test_load_copy();
		send_instr(OP_LOADI, 16'd5, 16'hFFFF);
		send_instr(OP_COPY, 16'd200, 16'hAB05);
		send_instr(OP_OUT, 16'd200, 16'h0000);
		send_instr(OP_LOADI, 16'hAB07, 16'h1234);
		send_instr(OP_OUT, 16'hFF07, 16'h5555);
	endtask

	// Flag setting through zero, through negative, and two's complement wrap
	task automatic test_arith_flags();
		send_instr(OP_LOADI, 16'(ACC_WORD), 16'd0);
		send_instr(OP_INC, 16'(ACC_WORD), 16'd0);       // 1: both flags clear
		send_instr(OP_DEC, 16'(ACC_WORD), 16'd0);       // 0: zero
		send_instr(OP_DEC, 16'(ACC_WORD), 16'd0);       // -1: negative
		send_instr(OP_ADDI, 16'd1, 16'hFFFF);           // wraps to zero
		send_instr(OP_DEC, 16'(ACC_WORD), 16'd0);
		send_instr(OP_ADDM, 16'(ACC_WORD), 16'd0);      // -1 + -1
		send_instr(OP_ADDM, 16'd5, 16'd0);              // add a memory word
		send_instr(OP_ADDI, 16'hFFFF, 16'd0);           // largest immediate
		send_instr(OP_OUT, 16'(ACC_WORD), 16'd0);
	endtask

	// Jump taken on a clear zero flag, not taken on a set one
	task automatic test_jump();
		send_instr(OP_JNZ, 16'h1234, 16'hFFFF);
		send_instr(OP_LOADI, 16'(ACC_WORD), 16'd0);
		send_instr(OP_ADDI, 16'd0, 16'd0);
		send_instr(OP_JNZ, 16'hFFAA, 16'd0);
	endtask

	// Unimplemented opcodes only advance the PC
	task automatic test_other_opcodes();
		send_instr(OP_SPARE, 16'(ACC_WORD), 16'hFFFF);
		send_instr(OP_TOP, 16'hFFFF, 16'hFFFF);
		send_instr(OP_HIGH, 16'h00A4, 16'h0001);
	endtask

	// ------------------------------------------------------------------
	// Random program: mostly legal opcodes over a small pool of addresses
	// so results feed later instructions; some wholly random beats.
	// ------------------------------------------------------------------
	function automatic opnd_t pick_addr();
		logic [7:0] pool [8];
		opnd_t      a;
		pool = '{ACC_ADDR, 8'd0, 8'd1, 8'd2, 8'd5, 8'd100, 8'd200, 8'd255};
		if ($urandom_range(0, 99) < 15)
			return 16'($urandom());
		a = {8'd0, pool[$urandom_range(0, 7)]};
		if ($urandom_range(0, 99) < 30)
			a[15:8] = 8'($urandom());
		return a;
	endfunction

	task automatic test_random_program();
		logic [7:0] ops [9];
		logic [7:0] op;
		opnd_t      a;
		opnd_t      b;
		int         r;
		ops = '{OP_NOP, OP_COPY, OP_LOADI, OP_ADDM, OP_ADDI,
			OP_INC, OP_DEC, OP_JNZ, OP_OUT};
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			// Alternate stretches with and without bubbles
			bubbles_on = ((i / 50) % 3) != 2;
			r = $urandom_range(0, 99);
			if (r < 10)
				op = 8'($urandom());
			else
				op = ops[$urandom_range(0, 8)];
			a = pick_addr();
			b = 16'($urandom());
			case (op)
				OP_COPY: b = pick_addr();
				OP_ADDI: a = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
				OP_LOADI: begin
					if ($urandom_range(0, 3) == 0)
						b = 16'($urandom_range(0, 2));
				end
				OP_JNZ: a = 16'($urandom());
				default: ;
			endcase
			send_instr(op, a, b);
		end
	endtask

	// ------------------------------------------------------------------
	// Run
	// ------------------------------------------------------------------
	initial begin
		clear_shadow();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_after_reset();
		test_load_copy();
		test_arith_flags();
		test_jump();
		test_other_opcodes();
		test_random_program();
		in_valid <= 1'b0;

		// Drain, then give the pipeline time to show any stray beat
		while (retire_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d instructions, %0d results checked, %0d outputs, %0d jumps taken.",
			beats_sent, beats_seen, prints_seen, jumps_taken);
		$display("Mismatches found: %0d", err_count);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tace_pkg.sv
rtl/tace_ram.sv
rtl/toy_accumulator_cpu_execute.sv
tb/sv/tb_top.sv
